>>> rtl/rnfd_pkg.sv
// Shared constants, register codes and helpers of the recursive neighbor filter.
`timescale 1ns / 1ps
`default_nettype none

package rnfd_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int DEF_PIXEL_BITS  = 16;
  localparam int DEF_WEIGHT_BITS = 16;

  // Weights are Q2.x: everything but two integer bits is fraction.
  localparam int WGT_INT_BITS = 2;

  localparam int CFG_DATA_BITS = 11;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_DATA_BITS-1:0] RESET_IMAGE_WIDTH  = CFG_DATA_BITS'(4);
  localparam logic [CFG_DATA_BITS-1:0] RESET_IMAGE_HEIGHT = CFG_DATA_BITS'(4);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // A size of zero acts as one, a size above the maximum acts as the maximum.
  function automatic logic [31:0] eff_dim(logic [CFG_DATA_BITS-1:0] v, int unsigned maxv);
    logic [31:0] res;
    if (v == '0) begin
      res = 32'd1;
    end else if (32'(v) > maxv) begin
      res = maxv;
    end else begin
      res = 32'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rnfd_in_if.sv
// Input and output channel interfaces of the recursive neighbor filter.
`timescale 1ns / 1ps
`default_nettype none

interface rnfd_in_if
  import rnfd_pkg::*;
#(
  parameter int PIXEL_BITS  = DEF_PIXEL_BITS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [PIXEL_BITS-1:0]  pixel_in;
  logic signed [WEIGHT_BITS-1:0] weight_self;
  logic signed [WEIGHT_BITS-1:0] weight_up;
  logic signed [WEIGHT_BITS-1:0] weight_up_left;
  logic signed [WEIGHT_BITS-1:0] weight_up_right;
  logic signed [WEIGHT_BITS-1:0] weight_left;

  modport source (
    output valid, pixel_in, weight_self, weight_up, weight_up_left, weight_up_right,
           weight_left,
    input  ready
  );
  modport sink (
    input  valid, pixel_in, weight_self, weight_up, weight_up_left, weight_up_right,
           weight_left,
    output ready
  );
endinterface

interface rnfd_out_if
  import rnfd_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel_out;
  logic                         plane_end;
  logic                         saturated;

  modport source (output valid, pixel_out, plane_end, saturated, input ready);
  modport sink (input valid, pixel_out, plane_end, saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/rnfd_linebuf.sv
// Line store: one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module rnfd_linebuf
  import rnfd_pkg::*;
#(
  parameter int DEPTH     = DEF_MAX_WIDTH,
  parameter int DATA_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  wire logic [DATA_BITS-1:0]         wr_data_i,
  input  wire logic                         rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr_b_i,
  output logic      [DATA_BITS-1:0]         rd_data_a_o,
  output logic      [DATA_BITS-1:0]         rd_data_b_o
);

  logic [DATA_BITS-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds while no read is issued, so a stalled consumer keeps it.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem_q[rd_addr_a_i];
      rd_data_b_o <= mem_q[rd_addr_b_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/recursive_neighbor_filter_down.sv
// Top level of the recursive four-neighbor spatial filter, downward raster pass.
`timescale 1ns / 1ps
`default_nettype none

// Pixels enter in raster order, one beat each, and every beat gives one result
// beat through the accept, product, partial-sum and output registers. The
// sustained rate is one pixel per cycle while the output is not stalled. It is
// set by the final stage, where the product of the left weight and the
// previous result is added, rounded and saturated before the output register.
// The line store keeps the previous row's results and is read at the pixel's
// column and the next column when the pixel is accepted; while a pixel still
// in the pipeline has not yet written one of those columns, input is held off.
// That happens only on rows after the first of planes narrower than five
// pixels, which then run slower. The line store needs no initialization. A
// size write starts a new plane; write sizes only while the block is empty.
module recursive_neighbor_filter_down
  import rnfd_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS  = DEF_PIXEL_BITS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  rnfd_in_if.sink                       in_if,
  rnfd_out_if.source                    out_if
);

  localparam int PB  = PIXEL_BITS;
  localparam int WB  = WEIGHT_BITS;
  localparam int WF  = WB - WGT_INT_BITS;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW  = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int PW  = PB + WB;
  localparam int PSW = PW + 2;
  localparam int ASW = PW + 3;

  localparam logic signed [ASW-1:0] HALF    = ASW'(1) << (WF - 1);
  localparam logic signed [PB-1:0]  PIX_MAX = {1'b0, {(PB - 1){1'b1}}};
  localparam logic signed [PB-1:0]  PIX_MIN = {1'b1, {(PB - 1){1'b0}}};

  // Plane size and position
  logic [WW-1:0] eff_w_q;
  logic [HW-1:0] eff_h_q;
  logic [AW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic [AW-1:0] col_next;
  logic          last_col;
  logic          last_row;

  // Pipeline control
  logic in_fire, adv1, adv2, adv3, out_fire;
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_free, s2_free, s3_free;
  logic hazard;

  // Stage 1: accepted pixel, line store data arrives
  logic signed [PB-1:0] s1_x_q;
  logic signed [WB-1:0] s1_ws_q, s1_wu_q, s1_wul_q, s1_wur_q, s1_wl_q;
  logic                 s1_up_ok_q, s1_ul_ok_q, s1_ur_ok_q, s1_left_ok_q, s1_last_q;
  logic [AW-1:0]        s1_col_q;
  logic [PB-1:0]        rd_a, rd_b;
  logic signed [PB-1:0] ul_q;
  logic signed [PB-1:0] nb_u, nb_ul, nb_ur;
  logic signed [PW-1:0] prod_self, prod_u, prod_ul, prod_ur;

  // Stage 2: four products
  logic signed [PW-1:0] s2_p_self_q, s2_p_u_q, s2_p_ul_q, s2_p_ur_q;
  logic signed [PB-1:0] s2_x_q;
  logic signed [WB-1:0] s2_wl_q;
  logic                 s2_left_ok_q, s2_last_q;
  logic [AW-1:0]        s2_col_q;

  // Stage 3: partial sum, left term added in the final step
  logic signed [PSW-1:0] s3_part_q;
  logic signed [PB-1:0]  s3_x_q;
  logic signed [WB-1:0]  s3_wl_q;
  logic                  s3_left_ok_q, s3_last_q;
  logic [AW-1:0]         s3_col_q;
  logic signed [PB-1:0]  nb_l;
  logic signed [PW-1:0]  prod_l;
  logic signed [ASW-1:0] acc;
  logic [ASW-WF-PB:0]    acc_hi;
  logic                  sat;
  logic signed [PB-1:0]  y;

  // Output register; its pixel is also the left neighbor of the next pixel
  logic signed [PB-1:0] pix_q;
  logic                 plane_end_q, sat_q;

  assign col_inc  = WW'(col_q) + WW'(1);
  assign row_inc  = HW'(row_q) + HW'(1);
  assign last_col = (col_inc == eff_w_q);
  assign last_row = (row_inc == eff_h_q);
  assign col_next = col_q + AW'(1);

  // Interlock: a pixel in flight has not yet written its column of the store.
  assign hazard = (row_q != '0) &&
                  ((s1_v_q && (s1_col_q == col_q || s1_col_q == col_next)) ||
                   (s2_v_q && (s2_col_q == col_q || s2_col_q == col_next)) ||
                   (s3_v_q && (s3_col_q == col_q || s3_col_q == col_next)));

  assign out_fire = out_v_q && out_if.ready;
  assign adv3     = s3_v_q && (!out_v_q || out_if.ready);
  assign s3_free  = !s3_v_q || adv3;
  assign adv2     = s2_v_q && s3_free;
  assign s2_free  = !s2_v_q || adv2;
  assign adv1     = s1_v_q && s2_free;
  assign s1_free  = !s1_v_q || adv1;

  assign in_if.ready = s1_free && !hazard;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= WW'(eff_dim(RESET_IMAGE_WIDTH, MAX_WIDTH));
      eff_h_q <= HW'(eff_dim(RESET_IMAGE_HEIGHT, MAX_HEIGHT));
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH: begin
          eff_w_q <= WW'(eff_dim(cfg_data_i, MAX_WIDTH));
          col_q   <= '0;
          row_q   <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          eff_h_q <= HW'(eff_dim(cfg_data_i, MAX_HEIGHT));
          col_q   <= '0;
          row_q   <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : RW'(row_inc);
      end else begin
        col_q <= col_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= in_fire;
      if (s2_free) s2_v_q <= adv1;
      if (s3_free) s3_v_q <= adv2;
      if (adv3 || out_fire) out_v_q <= adv3;
    end
  end

  rnfd_linebuf #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (PB)
  ) u_linebuf (
    .clk_i       (clk_i),
    .wr_en_i     (adv3),
    .wr_addr_i   (s3_col_q),
    .wr_data_i   (y),
    .rd_en_i     (in_fire),
    .rd_addr_a_i (col_q),
    .rd_addr_b_i (col_next),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q       <= in_if.pixel_in;
      s1_ws_q      <= in_if.weight_self;
      s1_wu_q      <= in_if.weight_up;
      s1_wul_q     <= in_if.weight_up_left;
      s1_wur_q     <= in_if.weight_up_right;
      s1_wl_q      <= in_if.weight_left;
      s1_up_ok_q   <= (row_q != '0);
      s1_ul_ok_q   <= (row_q != '0) && (col_q != '0);
      s1_ur_ok_q   <= (row_q != '0) && !last_col;
      s1_left_ok_q <= (col_q != '0);
      s1_last_q    <= last_col && last_row;
      s1_col_q     <= col_q;
    end
  end

  // Neighbors outside the plane take the pixel's own value.
  assign nb_u  = s1_up_ok_q ? $signed(rd_a) : s1_x_q;
  assign nb_ul = s1_ul_ok_q ? ul_q : s1_x_q;
  assign nb_ur = s1_ur_ok_q ? $signed(rd_b) : s1_x_q;

  assign prod_self = s1_x_q * s1_ws_q;
  assign prod_u    = nb_u * s1_wu_q;
  assign prod_ul   = nb_ul * s1_wul_q;
  assign prod_ur   = nb_ur * s1_wur_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      // The old store value above this pixel is the up-left of the next one.
      ul_q         <= $signed(rd_a);
      s2_p_self_q  <= prod_self;
      s2_p_u_q     <= prod_u;
      s2_p_ul_q    <= prod_ul;
      s2_p_ur_q    <= prod_ur;
      s2_x_q       <= s1_x_q;
      s2_wl_q      <= s1_wl_q;
      s2_left_ok_q <= s1_left_ok_q;
      s2_last_q    <= s1_last_q;
      s2_col_q     <= s1_col_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s3_part_q    <= PSW'(s2_p_self_q) + PSW'(s2_p_u_q) + PSW'(s2_p_ul_q) + PSW'(s2_p_ur_q);
      s3_x_q       <= s2_x_q;
      s3_wl_q      <= s2_wl_q;
      s3_left_ok_q <= s2_left_ok_q;
      s3_last_q    <= s2_last_q;
      s3_col_q     <= s2_col_q;
    end
  end

  assign nb_l   = s3_left_ok_q ? pix_q : s3_x_q;
  assign prod_l = nb_l * s3_wl_q;
  assign acc    = ASW'(s3_part_q) + ASW'(prod_l) + HALF;

  // Round half up is the floor after adding half; saturate when the bits
  // above the pixel's sign bit do not all match it.
  assign acc_hi = acc[ASW-1:WF+PB-1];
  assign sat    = !((&acc_hi) || !(|acc_hi));
  assign y      = !sat ? acc[WF+PB-1:WF] : (acc[ASW-1] ? PIX_MIN : PIX_MAX);

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      pix_q       <= y;
      plane_end_q <= s3_last_q;
      sat_q       <= sat;
    end
  end

  assign out_if.valid     = out_v_q;
  assign out_if.pixel_out = pix_q;
  assign out_if.plane_end = plane_end_q;
  assign out_if.saturated = sat_q;

endmodule

`default_nettype wire

>>> rtl/rnfd_checker.sv
// Port-level checks of the recursive neighbor filter, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module rnfd_checker
  import rnfd_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [PIXEL_BITS-1:0] out_pixel,
  input wire logic                  out_plane_end,
  input wire logic                  out_saturated
);

  logic       in_beat;
  logic       out_beat;
  logic [2:0] pending_q;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Beats accepted whose result beat has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_beat && !out_beat) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_beat && !in_beat) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) &&
                                $stable(out_plane_end) && $stable(out_saturated))
    else $error("result beat changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pending_q != 3'd0)
    else $error("result beat without an accepted pixel");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more pixels in flight than pipeline stages");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'd0 |-> in_ready)
    else $error("empty block refused a pixel");

endmodule

bind recursive_neighbor_filter_down rnfd_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_rnfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_pixel     (out_if.pixel_out),
  .out_plane_end (out_if.plane_end),
  .out_saturated (out_if.saturated)
);

`default_nettype wire
